/* rtl/tle_pkg.sv */
// Package of types and constants for the terminal line editor.
package tle_pkg;
   localparam int LINE_SIZE = 256;
   localparam int RING_SIZE = 1024;
   localparam int LINE_AW = $clog2(LINE_SIZE);
   localparam int LEN_W = $clog2(LINE_SIZE + 1);
   localparam int RING_AW = $clog2(RING_SIZE);

   localparam logic [2:0] KIND_ECHO  = 3'd0;
   localparam logic [2:0] KIND_ERASE = 3'd1;
   localparam logic [2:0] KIND_SIG   = 3'd2;
   localparam logic [2:0] KIND_DATA  = 3'd3;
   localparam logic [2:0] KIND_EMPTY = 3'd4;
   localparam logic [2:0] KIND_END   = 3'd5;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_INTR = 3'd1;
   localparam logic [2:0] REG_QUIT = 3'd2;
   localparam logic [2:0] REG_SUSP = 3'd3;
   localparam logic [2:0] REG_ERASE = 3'd4;
   localparam logic [2:0] REG_KILL = 3'd5;
   localparam logic [2:0] REG_EOF = 3'd6;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_BS = 8'd8;
   localparam logic [7:0] CHAR_DEL = 8'd127;
   localparam logic [7:0] CHAR_SP = 8'd32;
   localparam logic [7:0] CHAR_AT = 8'd64;
   localparam logic [7:0] CHAR_CARET = 8'd94;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic [7:0] count;
      logic [1:0] code;
   } result_type;
endpackage

/* rtl/tle_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module tle_ram #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/terminal_line_editor.sv */
// Top level of the terminal line editor.
// The req_ channel carries commands: tuser is cmd (0 feed a received byte,
// 1 read a ready byte) and tdata the received byte. The rsp_ channel returns
// up to four result beats per command; tlast marks the final one, tuser holds
// the kind and tdata holds out_byte, erase_count, signal_code, input_pending.
// The csr_ port writes the mode and special character registers; the user
// must write them only while idle, as the block itself does not enforce it.
// Commands are handled one at a time. A feed that only edits the line goes
// through the accept and then its result beats; a read goes through the
// accept, the ring read and the single result beat. A newline or EOF commit
// copies the pending line into the ready ring one byte per cycle through
// the line store read port, after a state that primes the read, and then
// gives its result beats. The line store and ready ring are single write,
// single read memories with registered read data.
// Reset clears the line length, ring pointers, end flag and registers to
// their defaults; no clearing pass runs. When the receiver holds rsp_tready
// low, results wait in a small result buffer and no new command is taken.
module terminal_line_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // in_byte
   input  logic        req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // out_byte, erase_count, signal_code, input_pending
   output logic [2:0]  rsp_tuser,  // kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import tle_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_COPY, ST_COPY_LAST, ST_OUT
   } state_type;

   state_type state_ff;
   logic [3:0] mode_ff;
   logic [7:0] intr_ff, quit_ff, susp_ff, erase_ff, kill_ff, eof_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [RING_AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic end_ff, end_in;
   result_type res_ff [4];
   result_type res_in [4];
   logic [2:0] nres_ff, nres_in;
   logic [1:0] oidx_ff;
   logic [LEN_W-1:0] cidx_ff;
   logic [7:0] cmd_byte;

   logic line_we, ring_we, feed_ring_we, line_we_g;
   logic [LINE_AW-1:0] line_wa, line_ra;
   logic [7:0] line_wd, line_rd;
   logic [RING_AW-1:0] ring_wa, ring_ra;
   logic [7:0] ring_wd, ring_rd;
   logic start_copy;

   tle_ram #(.DEPTH(LINE_SIZE), .AW(LINE_AW)) u_line (
      .clock, .wr_en(line_we_g), .wr_addr(line_wa), .wr_data(line_wd),
      .rd_addr(line_ra), .rd_data(line_rd));
   tle_ram #(.DEPTH(RING_SIZE), .AW(RING_AW)) u_ring (
      .clock, .wr_en(ring_we), .wr_addr(ring_wa), .wr_data(ring_wd),
      .rd_addr(ring_ra), .rd_data(ring_rd));

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
      ring_next = (p == RING_AW'(RING_SIZE - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic result_type mk(input logic [2:0] k, input logic [7:0] d,
                                     input logic [7:0] c, input logic [1:0] s);
      mk = '{kind: k, data: d, count: c, code: s};
   endfunction

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign cmd_byte = (mode_ff[0] && req_tdata == CHAR_CR) ? CHAR_LF : req_tdata;

   // Feed decode: results, memory writes and pointer updates for one byte.
   always_comb begin
      logic [2:0] n;
      logic is_sig;
      logic [1:0] sc;
      logic [7:0] c;
      logic [RING_AW-1:0] nx;
      n = '0;
      is_sig = 1'b0;
      sc = '0;
      c = cmd_byte;
      nx = ring_next(head_ff);
      for (int i = 0; i < 4; i++) res_in[i] = mk(KIND_ECHO, '0, '0, '0);
      len_in = len_ff;
      head_in = head_ff;
      end_in = end_ff;
      line_we = 1'b0;
      line_wa = len_ff[LINE_AW-1:0];
      line_wd = c;
      feed_ring_we = 1'b0;
      start_copy = 1'b0;
      if (mode_ff[1]) begin
         if (c == intr_ff) begin
            is_sig = 1'b1; sc = 2'd0;
         end else if (c == quit_ff) begin
            is_sig = 1'b1; sc = 2'd1;
         end else if (c == susp_ff) begin
            is_sig = 1'b1; sc = 2'd2;
         end
      end
      // Echo of c is placed first for signal, raw and ordinary paths.
      if (is_sig || !mode_ff[2] ||
          !(c == erase_ff || c == CHAR_DEL || c == kill_ff || c == eof_ff ||
            c == CHAR_LF)) begin
         if (mode_ff[3]) begin
            if (c == CHAR_LF) begin
               res_in[0] = mk(KIND_ECHO, CHAR_LF, '0, '0); n = 3'd1;
            end else if (c == CHAR_BS) begin
               res_in[0] = mk(KIND_ERASE, '0, 8'd1, '0); n = 3'd1;
            end else if (c >= CHAR_SP && c < CHAR_DEL) begin
               res_in[0] = mk(KIND_ECHO, c, '0, '0); n = 3'd1;
            end else if (c < CHAR_SP) begin
               res_in[0] = mk(KIND_ECHO, CHAR_CARET, '0, '0);
               res_in[1] = mk(KIND_ECHO, c + CHAR_AT, '0, '0);
               n = 3'd2;
            end
         end
      end
      if (is_sig) begin
         if (mode_ff[3]) begin
            res_in[n[1:0]] = mk(KIND_ECHO, CHAR_LF, '0, '0);
            n = n + 3'd1;
         end
         res_in[n[1:0]] = mk(KIND_SIG, '0, '0, sc);
         n = n + 3'd1;
         len_in = '0;
      end else if (!mode_ff[2]) begin
         if (nx != tail_ff) begin
            feed_ring_we = 1'b1;
            head_in = nx;
         end
      end else if (c == erase_ff || c == CHAR_DEL) begin
         n = '0;
         if (len_ff != '0) begin
            len_in = len_ff - 1'b1;
            if (mode_ff[3]) begin
               res_in[0] = mk(KIND_ERASE, '0, 8'd1, '0); n = 3'd1;
            end
         end
      end else if (c == kill_ff) begin
         n = '0;
         if (mode_ff[3] && len_ff != '0) begin
            res_in[0] = mk(KIND_ERASE, '0,
                           (len_ff > LEN_W'(255)) ? 8'd255 : len_ff[7:0], '0);
            n = 3'd1;
         end
         len_in = '0;
      end else if (c == eof_ff) begin
         n = '0;
         if (len_ff == '0) end_in = 1'b1;
         start_copy = 1'b1;
      end else if (c == CHAR_LF) begin
         n = '0;
         if (mode_ff[3]) begin
            res_in[0] = mk(KIND_ECHO, CHAR_LF, '0, '0); n = 3'd1;
         end
         if (len_ff < LEN_W'(LINE_SIZE)) begin
            line_we = 1'b1;
            line_wd = CHAR_LF;
            len_in = len_ff + 1'b1;
         end
         start_copy = 1'b1;
      end else if (len_ff + 1'b1 < LEN_W'(LINE_SIZE)) begin
         line_we = 1'b1;
         len_in = len_ff + 1'b1;
      end else begin
         n = '0;
      end
      nres_in = n;
   end

   // The line store read address runs one entry ahead of the copy so that
   // the data of entry cidx_ff arrives in the copy cycle that handles it.
   assign line_ra = (state_ff == ST_COPY) ? cidx_ff[LINE_AW-1:0] + 1'b1 : '0;
   assign ring_ra = tail_ff;

   logic copy_we;
   logic [RING_AW-1:0] copy_nx;
   assign copy_nx = ring_next(head_ff);
   assign copy_we = (state_ff == ST_COPY) && (copy_nx != tail_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= 4'd15;
         intr_ff <= 8'd3; quit_ff <= 8'd28; susp_ff <= 8'd26;
         erase_ff <= 8'd8; kill_ff <= 8'd21; eof_ff <= 8'd4;
         len_ff <= '0; head_ff <= '0; tail_ff <= '0; end_ff <= 1'b0;
         nres_ff <= '0; oidx_ff <= '0; cidx_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_MODE: mode_ff <= csr_wdata[3:0];
               REG_INTR: intr_ff <= csr_wdata;
               REG_QUIT: quit_ff <= csr_wdata;
               REG_SUSP: susp_ff <= csr_wdata;
               REG_ERASE: erase_ff <= csr_wdata;
               REG_KILL: kill_ff <= csr_wdata;
               REG_EOF: eof_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  oidx_ff <= '0;
                  if (req_tuser) begin
                     state_ff <= ST_READ;
                  end else begin
                     for (int i = 0; i < 4; i++) res_ff[i] <= res_in[i];
                     nres_ff <= nres_in;
                     head_ff <= head_in;
                     end_ff <= end_in;
                     cidx_ff <= '0;
                     if (start_copy && len_in != '0) begin
                        len_ff <= len_in;
                        state_ff <= ST_COPY_LAST;
                     end else begin
                        len_ff <= start_copy ? '0 : len_in;
                        state_ff <= (nres_in == '0) ? ST_IDLE : ST_OUT;
                     end
                  end
               end
            end
            ST_READ: begin
               nres_ff <= 3'd1;
               if (head_ff != tail_ff) begin
                  res_ff[0] <= mk(KIND_DATA, ring_rd, '0, '0);
                  tail_ff <= ring_next(tail_ff);
               end else if (end_ff) begin
                  res_ff[0] <= mk(KIND_END, '0, '0, '0);
                  end_ff <= 1'b0;
               end else begin
                  res_ff[0] <= mk(KIND_EMPTY, '0, '0, '0);
               end
               state_ff <= ST_OUT;
            end
            ST_COPY_LAST: begin
               // Wait for the first line byte to be read.
               state_ff <= ST_COPY;
            end
            ST_COPY: begin
               if (copy_we) head_ff <= copy_nx;
               cidx_ff <= cidx_ff + 1'b1;
               if (cidx_ff + 1'b1 == len_ff) begin
                  len_ff <= '0;
                  state_ff <= (nres_ff == '0) ? ST_IDLE : ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  oidx_ff <= oidx_ff + 1'b1;
                  if (rsp_tlast) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // In the copy, the line store read data of this cycle is at cidx_ff.
   always_comb begin
      if (state_ff == ST_COPY) begin
         ring_we = copy_we;
         ring_wa = head_ff;
         ring_wd = line_rd;
      end else if (state_ff == ST_IDLE && accept && !req_tuser) begin
         ring_we = feed_ring_we;
         ring_wa = head_ff;
         ring_wd = cmd_byte;
      end else begin
         ring_we = 1'b0;
         ring_wa = head_ff;
         ring_wd = cmd_byte;
      end
   end

   assign line_we_g = line_we && accept && !req_tuser;
   result_type cur;
   assign cur = res_ff[oidx_ff];
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tuser = cur.kind;
   assign rsp_tlast = ({1'b0, oidx_ff} + 3'd1 == nres_ff);
   assign rsp_tdata = {5'd0, (head_ff != tail_ff) || end_ff, cur.code,
                       cur.count, cur.data};
endmodule

/* rtl/tle_checker.sv */
// Port-level checker for the terminal line editor, bound to the top level.
module tle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import tle_pkg::*;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("command taken during results");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= KIND_END) else $error("bad kind");
   a_read_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_DATA || rsp_tuser == KIND_EMPTY ||
      rsp_tuser == KIND_END) |-> rsp_tlast) else $error("read gave more beats");
endmodule

bind terminal_line_editor tle_checker u_tle_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tuser, .rsp_tlast);
